[hw/rtl/ppisf_pkg.sv]
// ppisf_pkg: shared types, constants and helper functions for the
// periodic pairwise inverse-square force unit. No dependencies.
package ppisf_pkg;
  localparam int MaxParticlesDef = 32;
  localparam int PosW   = 32;
  localparam int ForceW = 40;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_COUPLING = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BOX      = 1'b1;
  localparam logic signed [ForceW-1:0] FORCE_MAX = {1'b0, {(ForceW-1){1'b1}}};
  localparam logic signed [ForceW-1:0] FORCE_MIN = {1'b1, {(ForceW-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_LOAD, ST_CLEAR, ST_PAIR, ST_DRAIN, ST_EMIT
  } state_t;

  // pair term handed from the pair unit to the accumulate stage
  typedef struct packed {
    logic                     valid;
    logic                     skip;
    logic signed [ForceW-1:0] term;
  } term_t;

  function automatic logic signed [ForceW-1:0] sat_add(
      input logic signed [ForceW-1:0] a, input logic signed [ForceW-1:0] b);
    logic signed [ForceW:0] s;
    s = {a[ForceW-1], a} + {b[ForceW-1], b};
    if (s[ForceW] != s[ForceW-1])
      return s[ForceW] ? FORCE_MIN : FORCE_MAX;
    return s[ForceW-1:0];
  endfunction

  function automatic logic signed [ForceW-1:0] sat_sub(
      input logic signed [ForceW-1:0] a, input logic signed [ForceW-1:0] b);
    logic signed [ForceW:0] s;
    s = {a[ForceW-1], a} - {b[ForceW-1], b};
    if (s[ForceW] != s[ForceW-1])
      return s[ForceW] ? FORCE_MIN : FORCE_MAX;
    return s[ForceW-1:0];
  endfunction
endpackage

[hw/rtl/ppisf_front.sv]
// ppisf_front: input side; stores positions, counts them and raises a
// start request on the last transfer. Depends on ppisf_pkg.
module ppisf_front #(
  parameter int MaxParticles = ppisf_pkg::MaxParticlesDef,
  parameter int IdxW = $clog2(MaxParticles + 1),
  parameter int AddrW = $clog2(MaxParticles)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ppisf_pkg::PosW-1:0]  in_pos,
  input  logic                        in_last,
  input  logic                        busy,
  input  logic                        clear,
  input  logic [AddrW-1:0]            rd_addr,
  output logic [ppisf_pkg::PosW-1:0]  rd_data,
  output logic                        start,
  output logic [IdxW-1:0]             count
);
  import ppisf_pkg::*;
  logic [PosW-1:0] mem [MaxParticles];
  logic acc;
  assign in_ready = !busy && !start;
  assign acc = in_valid && in_ready;
  always_ff @(posedge clk) begin
    if (acc && count < IdxW'(MaxParticles)) mem[count[AddrW-1:0]] <= in_pos;
    rd_data <= mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      start <= 1'b0;
    end else begin
      // count is held through the run and dropped on the final result
      if (clear) count <= '0;
      else if (acc && count < IdxW'(MaxParticles)) count <= count + 1'b1;
      if (acc && in_last) start <= 1'b1;
      else if (busy) start <= 1'b0;
    end
  end
endmodule

[hw/rtl/ppisf_div.sv]
// ppisf_div: radix-2 restoring divider, one quotient bit per cycle,
// 64-bit dividend over 61-bit divisor. No dependencies.
module ppisf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [60:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [6:0]  cnt;
  logic [61:0] rem;
  logic [63:0] q;
  logic [60:0] d;
  logic [62:0] trial;
  logic        run;
  assign trial = {rem, q[63]} - {2'b0, d};
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0; done <= 1'b0; cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1; cnt <= 7'd64; rem <= '0; q <= num; d <= den;
      end else if (run) begin
        if (!trial[62]) begin
          rem <= trial[61:0]; q <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[60:0], q[63]}; q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          run <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
  assign quo = q;
endmodule

[hw/rtl/periodic_pairwise_inverse_square_force_unit.sv]
// Periodic pairwise inverse-square force unit, top level.
// Load: one position per cycle while s_tready is high. After the last transfer, all
// N(N-1)/2 pairs run through a shared sequential pair unit (wrap mod L by 32
// restoring steps, square, 64-step divider; the divider is skipped when the
// wrapped separation is zero), then N result transfers. Inputs are held
// off from last to final result.
// rst is synchronous: clears the counter, sequencer and config to defaults.
module periodic_pairwise_inverse_square_force_unit #(
  parameter int MaxParticles = ppisf_pkg::MaxParticlesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // position[31:0]
  input  logic        s_tlast,     // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,     // force_res[39:0], particle_index[45:40], 0
  output logic        m_tlast,     // end_of_set
  input  logic        cfg_we,
  input  logic [ppisf_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [ppisf_pkg::CfgDataW-1:0] cfg_data
);
  import ppisf_pkg::*;
  localparam int IdxW = $clog2(MaxParticles + 1);
  localparam int AW = $clog2(MaxParticles);

  logic [31:0] coupling;
  logic [30:0] box_len;
  always_ff @(posedge clk) begin
    if (rst) begin
      coupling <= 32'd65536; box_len <= 31'd6553600;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_COUPLING) coupling <= cfg_data;
      if (cfg_idx == CFG_BOX) box_len <= cfg_data[30:0];
    end
  end

  state_t st, st_next;
  logic busy, start, set_done;
  logic [IdxW-1:0] n;
  logic [AW-1:0] rd_addr;
  logic [PosW-1:0] rd_data;
  assign busy = (st != ST_LOAD);
  // final result transfer ends the set and frees the loader
  assign set_done = (st == ST_EMIT) && m_tvalid && m_tready && m_tlast;

  ppisf_front #(.MaxParticles(MaxParticles), .AddrW(AW)) u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_pos(s_tdata),
    .in_last(s_tlast), .busy, .clear(set_done), .rd_addr, .rd_data, .start,
    .count(n));

  // accumulators: registers read at sequencer-chosen addresses
  logic signed [ForceW-1:0] acc [MaxParticles];
  logic [IdxW-1:0] pi, pj, ci;
  logic [4:0] ph;          // sub-step of one pair
  logic [5:0] wcnt;
  logic signed [PosW-1:0] xi;
  logic signed [32:0] dx;
  logic [32:0] len;
  logic [31:0] ux;         // |dx|, shifted out MSB first
  logic [32:0] rr;         // running remainder
  logic [32:0] rsh;
  logic [32:0] mod_t;
  logic signed [31:0] d;
  logic [30:0] mag;
  logic [60:0] d2;
  logic dgo, ddone;
  logic [63:0] q;
  term_t tq;
  logic pair_go, term_ready;

  ppisf_div u_div (.clk, .rst, .go(dgo), .num({coupling, 32'b0}),
    .den(d2), .done(ddone), .quo(q));

  always_comb begin
    st_next = st;
    case (st)
      ST_LOAD:  if (start) st_next = ST_CLEAR;
      ST_CLEAR: if (ci + 1'b1 >= n) st_next = (n > 1) ? ST_PAIR : ST_EMIT;
      ST_PAIR:  if (tq.valid && pi + IdxW'(2) >= n && pj + 1'b1 >= n) st_next = ST_EMIT;
      ST_EMIT:  if (m_tvalid && m_tready && m_tlast) st_next = ST_LOAD;
      default:  st_next = ST_LOAD;
    endcase
  end

  // restoring remainder step: shift in the next bit, subtract L if it fits
  assign rsh = {rr[31:0], ux[31]};
  // |dx| mod L mapped to dx mod L in [0, L)
  assign mod_t = (dx[32] && rr != 0) ? len - rr : rr;

  assign pair_go = (st == ST_PAIR) && (ph == 5'd9) && (d != 0);
  assign term_ready = (st == ST_PAIR) &&
                      (((ph == 5'd9) && (d == 0)) || ((ph == 5'd10) && ddone));

  // pair unit phases: 0 addr i, 1 addr j, 2 latch xi, 3 dx, 4 load wrap,
  // 5 wrap loop, 6 fold, 7 magnitude, 8 square, 9 launch, 10 wait div,
  // 11 accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_LOAD; ph <= '0; ci <= '0; pi <= '0; pj <= '0;
      m_tvalid <= 1'b0; dgo <= 1'b0; tq.valid <= 1'b0;
    end else begin
      st <= st_next;
      dgo <= pair_go;
      tq.valid <= term_ready;
      case (st)
        ST_LOAD: begin ci <= '0; pi <= '0; pj <= IdxW'(1); ph <= '0; end
        ST_CLEAR: begin
          acc[ci[AW-1:0]] <= '0;
          if (ci + 1'b1 >= n) ci <= '0;
          else ci <= ci + 1'b1;
        end
        ST_PAIR: begin
          case (ph)
            5'd0: begin rd_addr <= pi[AW-1:0]; ph <= 5'd1; end
            5'd1: begin rd_addr <= pj[AW-1:0]; ph <= 5'd2; end
            5'd2: begin xi <= rd_data; ph <= 5'd3; end
            5'd3: begin
              dx <= {xi[31], xi} - {rd_data[31], rd_data};
              len <= (box_len == 0) ? 33'd1 : {2'b0, box_len};
              ph <= 5'd4;
            end
            5'd4: begin
              // mod by shift-subtract on |dx| then fix sign
              ux <= dx[32] ? 32'(-dx) : dx[31:0];
              rr <= '0;
              wcnt <= 6'd32; ph <= 5'd5;
            end
            5'd5: begin
              if (wcnt != 0) begin
                wcnt <= wcnt - 1'b1;
                ux <= {ux[30:0], 1'b0};
                if (rsh >= len) rr <= rsh - len;
                else rr <= rsh;
              end else ph <= 5'd6;
            end
            5'd6: begin
              // fold into [-L/2, L/2)
              if ({mod_t, 1'b0} >= {1'b0, len}) d <= 32'(mod_t) - 32'(len);
              else d <= 32'(mod_t);
              ph <= 5'd7;
            end
            5'd7: begin mag <= d[31] ? 31'(-d) : d[30:0]; ph <= 5'd8; end
            5'd8: begin
              d2 <= mag * mag;
              ph <= 5'd9;
            end
            5'd9: begin
              if (d == 0) begin tq.skip <= 1'b1; ph <= 5'd11; end
              else ph <= 5'd10;
            end
            5'd10: if (ddone) begin
              tq.skip <= 1'b0;
              if (q > 64'(FORCE_MAX)) tq.term <= d[31] ? FORCE_MIN : FORCE_MAX;
              else tq.term <= d[31] ? -ForceW'(q) : ForceW'(q);
              ph <= 5'd11;
            end
            default: begin
              if (!tq.skip) begin
                acc[pi[AW-1:0]] <= sat_add(acc[pi[AW-1:0]], tq.term);
                acc[pj[AW-1:0]] <= sat_sub(acc[pj[AW-1:0]], tq.term);
              end
              if (pj + 1'b1 >= n) begin pi <= pi + 1'b1; pj <= pi + IdxW'(2); end
              else pj <= pj + 1'b1;
              ph <= '0;
            end
          endcase
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            if (ci < n && !(m_tvalid && m_tlast)) begin
              m_tvalid <= 1'b1;
              m_tdata <= {2'b0, 6'(ci), acc[ci[AW-1:0]]};
              m_tlast <= (ci + 1'b1 == n) || (n == 0);
              ci <= ci + 1'b1;
            end else m_tvalid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // loader closed while computing; results only in emit; count bounded
  assert property (@(posedge clk) disable iff (rst) busy |-> !s_tready)
    else $error("input taken during compute");
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> st == ST_EMIT)
    else $error("result outside emit");
  assert property (@(posedge clk) disable iff (rst) n <= IdxW'(MaxParticles))
    else $error("count overflow");
endmodule

[sim/testbench.sv]
// Testbench for periodic_pairwise_inverse_square_force_unit: loads particle sets,
// predicts every pair force sum and checks the emitted forces in order.
// Depends on hw/rtl/ppisf_pkg.sv and the top-level RTL.
`timescale 1ns / 100ps

module testbench;
  import ppisf_pkg::*;

  localparam int      NumSlots = 32;
  localparam longint  ForceHi  = 64'sd549755813887;
  localparam longint  ForceLo  = -64'sd549755813888;

  typedef struct {
    logic [31:0] pos;
    logic        last;
  } particle_t;

  typedef struct {
    logic [39:0] force_val;
    logic [5:0]  idx;
    logic        eos;
  } force_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [31:0]        s_tdata = '0;    // position[31:0]
  logic               s_tlast = 1'b0;  // last
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [47:0]        m_tdata;         // force_res[39:0], particle_index[45:40], 0
  logic               m_tlast;         // end_of_set
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CFG_COUPLING;
  logic [CfgDataW-1:0] cfg_data = '0;

  periodic_pairwise_inverse_square_force_unit dut (.*);

  always #2 clk = ~clk;

  // predictor state: mirrored registers and the loaded set
  logic [31:0] eps_reg = 32'd65536;
  logic [30:0] len_reg = 31'd6553600;
  longint      set_pos [NumSlots];
  int          set_cnt = 0;

  particle_t   pending_q[$];
  force_t      forces_due[$];
  int          mismatches = 0;
  bit          in_xfer = 1'b0;

  // minimum-image wrap into [-L/2, L/2); a zero length acts as one raw unit
  function automatic longint wrap_dist(longint dx);
    longint len, t;
    len = (len_reg == 0) ? 64'sd1 : longint'(len_reg);
    t = dx % len;
    if (t < 0) t += len;
    if (2 * t >= len) t -= len;
    return t;
  endfunction

  // sign(d) * eps / d^2 in signed Q24.16, magnitude truncated, clamped
  function automatic longint pair_force(longint d);
    longint unsigned mag, d2, q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    d2  = mag * mag;
    q   = {eps_reg, 32'h0} / d2;
    if (q > longint'(ForceHi)) return (d > 0) ? ForceHi : ForceLo;
    return (d > 0) ? longint'(q) : -longint'(q);
  endfunction

  function automatic longint clamp_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ForceHi) return ForceHi;
    if (s < ForceLo) return ForceLo;
    return s;
  endfunction

  // one accepted particle: store it, and on last compute the whole set
  function automatic void predict_particle(logic [31:0] pos, logic last);
    longint acc [NumSlots];
    longint d, f;
    force_t r;
    if (set_cnt < NumSlots) begin
      set_pos[set_cnt] = longint'(signed'(pos));
      set_cnt++;
    end
    if (!last) return;
    for (int i = 0; i < set_cnt; i++) acc[i] = 0;
    for (int i = 0; i < set_cnt; i++) begin
      for (int j = i + 1; j < set_cnt; j++) begin
        d = wrap_dist(set_pos[i] - set_pos[j]);
        if (d != 0) begin
          f = pair_force(d);
          acc[i] = clamp_sum(acc[i], f);
          acc[j] = clamp_sum(acc[j], -f);
        end
      end
    end
    for (int i = 0; i < set_cnt; i++) begin
      r.force_val = acc[i][39:0];
      r.idx       = i[5:0];
      r.eos       = (i == set_cnt - 1);
      forces_due.push_back(r);
    end
    set_cnt = 0;
  endfunction

  // driver: bursts of transfers separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_xfer)) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        particle_t p;
        p = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= p.pos;
        s_tlast  <= p.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: the stall odds are redrawn after a random hold
  int stall_pct = 0;
  int stall_age = 0;
  always @(negedge clk) begin
    if (stall_age == 0) begin
      stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      stall_age <= $urandom_range(50, 400);
    end else begin
      stall_age <= stall_age - 1;
    end
    m_tready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    in_xfer <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) predict_particle(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) begin
      if (forces_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected force transfer data=%h last=%b", m_tdata, m_tlast);
      end else begin
        force_t w;
        w = forces_due.pop_front();
        if (m_tdata[39:0] !== w.force_val || m_tdata[45:40] !== w.idx
            || m_tlast !== w.eos) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: particle %0d exp force=%h idx=%0d eos=%b, got %h %0d %b",
                     w.idx, w.force_val, w.idx, w.eos,
                     m_tdata[39:0], m_tdata[45:40], m_tlast);
        end
      end
    end
  end

  task automatic add_particle(input logic [31:0] pos, input logic last);
    particle_t p;
    p.pos  = pos;
    p.last = last;
    pending_q.push_back(p);
  endtask

  // hold until the set is fully loaded and every force has come back
  task automatic wait_idle();
    while (pending_q.size() != 0 || s_tvalid || forces_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    if (idx == CFG_COUPLING) eps_reg = val;
    else len_reg = val[30:0];
  endtask

  // random set: clustered positions make real forces, loose ones test wrap
  task automatic random_set(input int n);
    logic [31:0] base;
    base = $urandom;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 2) == 0)
        add_particle($urandom, k == n - 1);
      else
        add_particle(base + $urandom_range(0, 32'h0008_0000), k == n - 1);
    end
    wait_idle();
  endtask

  int sent;
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // single particle: one zero force
    add_particle(32'h0001_0000, 1'b1);
    wait_idle();
    // position extremes under the default box
    add_particle(32'h8000_0000, 1'b0);
    add_particle(32'h7FFF_FFFF, 1'b1);
    wait_idle();
    // coincident particles skip their pair
    add_particle(32'h0005_0000, 1'b0);
    add_particle(32'h0005_0000, 1'b0);
    add_particle(32'h0007_0000, 1'b1);
    wait_idle();
    // largest coupling, one raw unit apart: term and sum saturation
    write_reg(CFG_COUPLING, 32'hFFFF_FFFF);
    add_particle(32'h0000_0000, 1'b0);
    add_particle(32'h0000_0001, 1'b0);
    add_particle(32'h0000_0002, 1'b1);
    wait_idle();
    // largest box with extreme positions
    write_reg(CFG_BOX, 32'h7FFF_FFFF);
    add_particle(32'h8000_0000, 1'b0);
    add_particle(32'h7FFF_FFFF, 1'b0);
    add_particle(32'h0000_0000, 1'b1);
    wait_idle();
    // zero box length acts as one raw unit: everything wraps to zero
    write_reg(CFG_BOX, 32'h0);
    add_particle(32'h0000_0001, 1'b0);
    add_particle(32'h0003_0002, 1'b1);
    wait_idle();
    // zero coupling, smallest box
    write_reg(CFG_COUPLING, 32'h0);
    write_reg(CFG_BOX, 32'h1);
    add_particle(32'hFFFF_FFFF, 1'b0);
    add_particle(32'h1234_5678, 1'b1);
    wait_idle();

    // overfull set: extra items dropped, dropped last still starts the sums
    write_reg(CFG_COUPLING, 32'd65536);
    write_reg(CFG_BOX, 32'd6553600);
    for (int k = 0; k < NumSlots + 2; k++)
      add_particle(32'h0001_0000 * k + $urandom_range(0, 16'hFFFF), k == NumSlots + 1);
    wait_idle();

    sent = 0;
    while (sent < 60) begin
      int n;
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_COUPLING, ($urandom_range(0, 3) == 0) ? $urandom
                                 : $urandom_range(32'h100, 32'h40_0000));
        write_reg(CFG_BOX, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 32'h7FFF_FFFF)
                            : $urandom_range(32'h1_0000, 32'h100_0000));
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      random_set(n);
      sent += n;
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/ppisf_pkg.sv
hw/rtl/ppisf_front.sv
hw/rtl/ppisf_div.sv
hw/rtl/periodic_pairwise_inverse_square_force_unit.sv
sim/testbench.sv
